// ===== rtl/pfvi_pkg.sv =====
package pfvi_pkg;

  localparam int unsigned DIV_NW = 64;
  localparam int unsigned DIV_DW = 33;
  localparam int unsigned CFG_AW = 3;

  localparam logic [46:0] SUM_LIM = 47'h7FFF_FFFF_FFFF;

  localparam logic [CFG_AW-1:0] REG_RADIUS   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_FSCALE   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_KEEP     = 3'd2;
  localparam logic [CFG_AW-1:0] REG_DT       = 3'd3;
  localparam logic [CFG_AW-1:0] REG_WORLD    = 3'd4;
  localparam logic [CFG_AW-1:0] REG_PERIODIC = 3'd5;

  localparam logic [31:0] RST_RADIUS = 32'd65536;
  localparam logic [31:0] RST_FSCALE = 32'd65536;
  localparam logic [15:0] RST_KEEP   = 16'd65535;
  localparam logic [31:0] RST_DT     = 32'd655;
  localparam logic [31:0] RST_WORLD  = 32'd65536000;

endpackage

// ===== rtl/pfvi_div.sv =====
module pfvi_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pfvi_pkg::DIV_NW-1:0]  num_i,
  input  logic [pfvi_pkg::DIV_DW-1:0]  den_i,
  output logic                         done_o,
  output logic [pfvi_pkg::DIV_NW-1:0]  quo_o,
  output logic [pfvi_pkg::DIV_DW-1:0]  rem_o
);
  logic [6:0]                    cnt_q;
  logic                          done_q;
  logic [pfvi_pkg::DIV_NW-1:0]   quo_q;
  logic [pfvi_pkg::DIV_DW-1:0]   rem_q;
  logic [pfvi_pkg::DIV_DW-1:0]   den_q;
  logic [pfvi_pkg::DIV_DW:0]     sh;
  logic                          ge;

  assign sh = {rem_q, quo_q[pfvi_pkg::DIV_NW-1]};
  assign ge = sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= 7'(pfvi_pkg::DIV_NW);
        quo_q <= num_i;
        rem_q <= '0;
        den_q <= den_i;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 7'd1;
        quo_q <= {quo_q[pfvi_pkg::DIV_NW-2:0], ge};
        rem_q <= ge ? pfvi_pkg::DIV_DW'(sh - {1'b0, den_q}) : sh[pfvi_pkg::DIV_DW-1:0];
        if (cnt_q == 7'd1) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
endmodule

// ===== rtl/pfvi_sqrt.sv =====
module pfvi_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  output logic        done_o,
  output logic [31:0] root_o
);
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [63:0] xs_q;
  logic [34:0] rem_q;
  logic [31:0] root_q;
  logic [34:0] rm;
  logic [34:0] trial;
  logic        ge;

  assign rm    = {rem_q[32:0], xs_q[63:62]};
  assign trial = {1'b0, root_q, 2'b01};
  assign ge    = rm >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        xs_q   <= x_i;
        rem_q  <= '0;
        root_q <= '0;
      end else if (busy_q) begin
        cnt_q  <= cnt_q + 6'd1;
        xs_q   <= {xs_q[61:0], 2'b00};
        rem_q  <= ge ? rm - trial : rm;
        root_q <= {root_q[30:0], ge};
        if (cnt_q == 6'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

// ===== rtl/pair_force_velocity_integrator_unit.sv =====
// Particle-life force accumulator and integrator. Each input transaction is one
// neighbor of the particle being updated; a transaction with tlast finishes the
// particle and yields one output transaction with the new velocity and position,
// then clears the force sums. All work runs through one shared 32x32 multiplier,
// one radix-2 divider and one bit-pair square root, so the block takes one
// transaction at a time: an interacting neighbor needs the square root and up
// to four divisions, and the finishing step divides once per axis, plus once
// more per axis when a periodic position must be wrapped.
module pair_force_velocity_integrator_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // self_x, self_y, other_x, other_y, attraction, min_dist, vel_x, vel_y, mass
  input  logic [247:0]                s_axis_tdata,
  // skip_pair
  input  logic                        s_axis_tuser,
  input  logic                        s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // new_vel_x, new_vel_y, new_pos_x, new_pos_y
  output logic [127:0]                m_axis_tdata,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [pfvi_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [31:0]                 cfg_data_i
);
  localparam logic [4:0] ST_IDLE = 5'd0,  ST_DXY = 5'd1,  ST_SQY = 5'd2,  ST_SQR = 5'd3;
  localparam logic [4:0] ST_CHK  = 5'd4,  ST_SQRT = 5'd5, ST_DR  = 5'd6,  ST_DF  = 5'd7;
  localparam logic [4:0] ST_FT   = 5'd8,  ST_PX  = 5'd9,  ST_PXS = 5'd10, ST_PXD = 5'd11;
  localparam logic [4:0] ST_PYS  = 5'd12, ST_PYD = 5'd13, ST_FA  = 5'd14, ST_FB  = 5'd15;
  localparam logic [4:0] ST_FC   = 5'd16, ST_FD  = 5'd17, ST_FE  = 5'd18, ST_FF  = 5'd19;
  localparam logic [4:0] ST_FG   = 5'd20, ST_FH  = 5'd21, ST_FJ  = 5'd22, ST_FK  = 5'd23;
  localparam logic [4:0] ST_FL   = 5'd24, ST_FM  = 5'd25, ST_FN  = 5'd26, ST_FP  = 5'd27;
  localparam logic [4:0] ST_ST   = 5'd28, ST_EMIT = 5'd29;

  logic [4:0]  state_q;
  logic [31:0] rad_q, fsc_q, dt_q, wld_q;
  logic [15:0] keep_q;
  logic        per_q;
  logic signed [47:0] sum_x_q, sum_y_q;

  logic [31:0] sx_q, sy_q, ox_q, oy_q;
  logic signed [15:0] a_q;
  logic [15:0] beta_q;
  logic        skip_q, last_q;
  logic signed [31:0] vx_q, vy_q;
  logic [23:0] mass_q;

  logic        dxneg_q, dyneg_q;
  logic [31:0] mx_q, my_q, d_q;
  logic [63:0] qx_q, prod_q, hi_q;
  logic        rep_q, fneg_q, finneg_q, axis_q;
  logic [16:0] fmag_q;
  logic [46:0] fm_q;
  logic [30:0] vk_q;
  logic [62:0] acc_q;
  logic signed [31:0] v_q;
  logic signed [49:0] p_q;
  logic [31:0] pos_q;
  logic [31:0] nvx_q, nvy_q, npx_q, npy_q;
  logic        out_valid_q;

  logic        div_go_q, sq_go_q;
  logic [pfvi_pkg::DIV_NW-1:0] div_num_q, div_quo;
  logic [pfvi_pkg::DIV_DW-1:0] div_den_q, div_rem;
  logic        div_done, sq_done;
  logic [63:0] sq_x_q;
  logic [31:0] sq_root;

  logic [31:0] mul_a, mul_b;
  logic [32:0] wsz;
  logic signed [35:0] w36, dxr, dyr, dxm, dym;
  logic [35:0] mxf, myf;
  logic        pair_ok;
  logic [64:0] sq65;
  logic [15:0] r_w;
  logic signed [18:0] ts;
  logic [17:0] tmag;
  logic [16:0] tent, amag;
  logic signed [47:0] sumsel;
  logic [47:0] summag;
  logic signed [31:0] velsel;
  logic [32:0] velmag;
  logic [23:0] mass_eff;
  logic [46:0] q16_w, adj_w;
  logic signed [49:0] padd, qadd;
  logic [31:0] vmag;
  logic [47:0] dm;
  logic signed [49:0] ps, w50;
  logic [31:0] selfsel;
  logic signed [48:0] vsum;

  function automatic logic [46:0] q16sat(input logic [63:0] hi, input logic [63:0] lo);
    logic [48:0] v;
    v = {2'b00, hi[30:0], 16'h0000} + {1'b0, lo[63:16]};
    if (hi > 64'h7FFF_FFFF) begin
      return pfvi_pkg::SUM_LIM;
    end else if (v > {2'b00, pfvi_pkg::SUM_LIM}) begin
      return pfvi_pkg::SUM_LIM;
    end
    return v[46:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    if (v > $signed({3'b000, pfvi_pkg::SUM_LIM})) begin
      return $signed({1'b0, pfvi_pkg::SUM_LIM});
    end else if (v < -$signed({3'b000, pfvi_pkg::SUM_LIM})) begin
      return -$signed({1'b0, pfvi_pkg::SUM_LIM});
    end
    return v[47:0];
  endfunction

  assign wsz = (wld_q == '0) ? 33'h1_0000_0000 : {1'b0, wld_q};
  assign w36 = $signed({3'b000, wsz});
  assign w50 = $signed({17'h0, wsz});

  always_comb begin
    dxr = $signed({4'h0, ox_q}) - $signed({4'h0, sx_q});
    dyr = $signed({4'h0, oy_q}) - $signed({4'h0, sy_q});
    dxm = dxr;
    dym = dyr;
    if (per_q) begin
      if ((dxr <<< 1) > w36) begin
        dxm = dxr - w36;
      end else if ((dxr <<< 1) < -w36) begin
        dxm = dxr + w36;
      end
      if ((dyr <<< 1) > w36) begin
        dym = dyr - w36;
      end else if ((dyr <<< 1) < -w36) begin
        dym = dyr + w36;
      end
    end
    mxf = dxm[35] ? 36'(-dxm) : 36'(dxm);
    myf = dym[35] ? 36'(-dym) : 36'(dym);
    pair_ok = !skip_q && (mxf < {4'h0, rad_q}) && (myf < {4'h0, rad_q});
  end

  assign sq65  = {1'b0, qx_q} + {1'b0, prod_q};
  assign r_w   = div_quo[15:0];
  assign ts    = $signed({2'b00, r_w, 1'b0}) - 19'sd65536 - $signed({3'b000, beta_q});
  assign tmag  = ts[18] ? 18'(-ts) : 18'(ts);
  assign tent  = 17'h10000 - div_quo[16:0];
  assign amag  = a_q[15] ? 17'(-$signed({a_q[15], a_q})) : {1'b0, a_q};

  assign sumsel   = axis_q ? sum_y_q : sum_x_q;
  assign summag   = sumsel[47] ? 48'(-sumsel) : 48'(sumsel);
  assign velsel   = axis_q ? vy_q : vx_q;
  assign velmag   = velsel[31] ? 33'(-$signed({velsel[31], velsel})) : {1'b0, velsel};
  assign selfsel  = axis_q ? sy_q : sx_q;
  assign mass_eff = (mass_q == '0) ? 24'd1 : mass_q;
  assign vmag     = v_q[31] ? 32'(-$signed({v_q[31], v_q})) : 32'(v_q);

  assign q16_w = q16sat(hi_q, prod_q);
  assign adj_w = q16sat(hi_q, prod_q);
  assign qadd  = (dxneg_q ^ fneg_q) ? -$signed({33'h0, div_quo[16:0]})
                                    : $signed({33'h0, div_quo[16:0]});
  assign padd  = (dyneg_q ^ fneg_q) ? -$signed({33'h0, div_quo[16:0]})
                                    : $signed({33'h0, div_quo[16:0]});
  assign vsum  = (velsel[31] ? -$signed({18'h0, vk_q}) : $signed({18'h0, vk_q}))
               + (finneg_q ? -$signed({2'b00, adj_w}) : $signed({2'b00, adj_w}));
  assign dm    = prod_q[63:16];
  assign ps    = $signed({18'h0, selfsel})
               + (v_q[31] ? -$signed({3'b000, (dm > {1'b0, pfvi_pkg::SUM_LIM}) ?
                                               pfvi_pkg::SUM_LIM : dm[46:0]})
                          :  $signed({3'b000, (dm > {1'b0, pfvi_pkg::SUM_LIM}) ?
                                               pfvi_pkg::SUM_LIM : dm[46:0]}));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_DXY:       begin mul_a = mxf[31:0]; mul_b = mxf[31:0]; end
      ST_SQY:       begin mul_a = my_q; mul_b = my_q; end
      ST_SQR:       begin mul_a = rad_q; mul_b = rad_q; end
      ST_DF:        begin mul_a = {15'h0, amag}; mul_b = {15'h0, tent}; end
      ST_PX:        begin mul_a = mx_q; mul_b = {15'h0, fmag_q}; end
      ST_PXD:       begin mul_a = my_q; mul_b = {15'h0, fmag_q}; end
      ST_FA:        begin mul_a = {17'h0, summag[46:32]}; mul_b = rad_q; end
      ST_FB:        begin mul_a = summag[31:0]; mul_b = rad_q; end
      ST_FD:        begin mul_a = {17'h0, fm_q[46:32]}; mul_b = fsc_q; end
      ST_FE:        begin mul_a = fm_q[31:0]; mul_b = fsc_q; end
      ST_FG, ST_FH: begin mul_a = velmag[31:0]; mul_b = {16'h0, keep_q}; end
      ST_FJ:        begin mul_a = {1'b0, acc_q[62:32]}; mul_b = dt_q; end
      ST_FK:        begin mul_a = acc_q[31:0]; mul_b = dt_q; end
      ST_FM:        begin mul_a = vmag; mul_b = dt_q; end
      default:      begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(mul_a) * 64'(mul_b);
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rad_q       <= pfvi_pkg::RST_RADIUS;
      fsc_q       <= pfvi_pkg::RST_FSCALE;
      keep_q      <= pfvi_pkg::RST_KEEP;
      dt_q        <= pfvi_pkg::RST_DT;
      wld_q       <= pfvi_pkg::RST_WORLD;
      per_q       <= 1'b1;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      out_valid_q <= 1'b0;
      div_go_q    <= 1'b0;
      sq_go_q     <= 1'b0;
      axis_q      <= 1'b0;
    end else begin
      div_go_q <= 1'b0;
      sq_go_q  <= 1'b0;
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_addr_i)
          pfvi_pkg::REG_RADIUS:   rad_q  <= cfg_data_i;
          pfvi_pkg::REG_FSCALE:   fsc_q  <= cfg_data_i;
          pfvi_pkg::REG_KEEP:     keep_q <= cfg_data_i[15:0];
          pfvi_pkg::REG_DT:       dt_q   <= cfg_data_i;
          pfvi_pkg::REG_WORLD:    wld_q  <= cfg_data_i;
          pfvi_pkg::REG_PERIODIC: per_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            sx_q    <= s_axis_tdata[31:0];
            sy_q    <= s_axis_tdata[63:32];
            ox_q    <= s_axis_tdata[95:64];
            oy_q    <= s_axis_tdata[127:96];
            a_q     <= s_axis_tdata[143:128];
            beta_q  <= s_axis_tdata[159:144];
            vx_q    <= s_axis_tdata[191:160];
            vy_q    <= s_axis_tdata[223:192];
            mass_q  <= s_axis_tdata[247:224];
            skip_q  <= s_axis_tuser;
            last_q  <= s_axis_tlast;
            state_q <= ST_DXY;
          end
        end
        ST_DXY: begin
          dxneg_q <= dxm[35];
          dyneg_q <= dym[35];
          mx_q    <= mxf[31:0];
          my_q    <= myf[31:0];
          axis_q  <= 1'b0;
          if (pair_ok) begin
            state_q <= ST_SQY;
          end else begin
            state_q <= last_q ? ST_FA : ST_IDLE;
          end
        end
        ST_SQY: begin
          qx_q    <= prod_q;
          state_q <= ST_SQR;
        end
        ST_SQR: begin
          qx_q    <= sq65[63:0];
          state_q <= ST_CHK;
        end
        ST_CHK: begin
          if (!sq65[64] && (qx_q != '0) && (qx_q < prod_q)) begin
            sq_x_q  <= qx_q;
            sq_go_q <= 1'b1;
            state_q <= ST_SQRT;
          end else begin
            state_q <= last_q ? ST_FA : ST_IDLE;
          end
        end
        ST_SQRT: begin
          if (sq_done) begin
            d_q       <= sq_root;
            div_num_q <= {16'h0, sq_root, 16'h0};
            div_den_q <= {1'b0, rad_q};
            div_go_q  <= 1'b1;
            state_q   <= ST_DR;
          end
        end
        ST_DR: begin
          if (div_done) begin
            if (r_w < beta_q) begin
              div_num_q <= {32'h0, 16'(beta_q - r_w), 16'h0};
              div_den_q <= {17'h0, beta_q};
              div_go_q  <= 1'b1;
              rep_q     <= 1'b1;
              fneg_q    <= 1'b1;
              state_q   <= ST_DF;
            end else if (r_w > beta_q) begin
              div_num_q <= {30'h0, tmag, 16'h0};
              div_den_q <= {16'h0, 17'(17'h10000 - {1'b0, beta_q})};
              div_go_q  <= 1'b1;
              rep_q     <= 1'b0;
              fneg_q    <= a_q[15];
              state_q   <= ST_DF;
            end else begin
              state_q <= last_q ? ST_FA : ST_IDLE;
            end
          end
        end
        ST_DF: begin
          if (div_done) begin
            if (rep_q) begin
              fmag_q  <= div_quo[16:0];
              state_q <= ST_PX;
            end else begin
              state_q <= ST_FT;
            end
          end
        end
        ST_FT: begin
          fmag_q  <= prod_q[31:15];
          state_q <= ST_PX;
        end
        ST_PX: begin
          state_q <= ST_PXS;
        end
        ST_PXS: begin
          div_num_q <= prod_q;
          div_den_q <= {1'b0, d_q};
          div_go_q  <= 1'b1;
          state_q   <= ST_PXD;
        end
        ST_PXD: begin
          if (div_done) begin
            sum_x_q <= sat48(50'(sum_x_q) + qadd);
            state_q <= ST_PYS;
          end
        end
        ST_PYS: begin
          div_num_q <= prod_q;
          div_den_q <= {1'b0, d_q};
          div_go_q  <= 1'b1;
          state_q   <= ST_PYD;
        end
        ST_PYD: begin
          if (div_done) begin
            sum_y_q <= sat48(50'(sum_y_q) + padd);
            state_q <= last_q ? ST_FA : ST_IDLE;
          end
        end
        ST_FA: begin
          state_q <= ST_FB;
        end
        ST_FB: begin
          hi_q    <= prod_q;
          state_q <= ST_FC;
        end
        ST_FC: begin
          fm_q     <= q16_w;
          finneg_q <= sumsel[47];
          state_q  <= ST_FD;
        end
        ST_FD: begin
          state_q <= ST_FE;
        end
        ST_FE: begin
          hi_q    <= prod_q;
          state_q <= ST_FF;
        end
        ST_FF: begin
          fm_q    <= q16_w;
          state_q <= ST_FG;
        end
        ST_FG: begin
          div_num_q <= {1'b0, fm_q, 16'h0};
          div_den_q <= {9'h0, mass_eff};
          div_go_q  <= 1'b1;
          state_q   <= ST_FH;
        end
        ST_FH: begin
          vk_q <= prod_q[46:16];
          if (div_done) begin
            acc_q   <= div_quo[62:0];
            state_q <= ST_FJ;
          end
        end
        ST_FJ: begin
          state_q <= ST_FK;
        end
        ST_FK: begin
          hi_q    <= prod_q;
          state_q <= ST_FL;
        end
        ST_FL: begin
          if (vsum > 49'sd2147483647) begin
            v_q <= 32'sh7FFF_FFFF;
          end else if (vsum < -49'sd2147483648) begin
            v_q <= 32'sh8000_0000;
          end else begin
            v_q <= vsum[31:0];
          end
          state_q <= ST_FM;
        end
        ST_FM: begin
          state_q <= ST_FN;
        end
        ST_FN: begin
          p_q <= ps;
          if (per_q) begin
            if (!ps[49] && (ps < w50)) begin
              pos_q   <= ps[31:0];
              state_q <= ST_ST;
            end else begin
              div_num_q <= ps[49] ? 64'(-ps) : 64'(ps);
              div_den_q <= wsz;
              div_go_q  <= 1'b1;
              state_q   <= ST_FP;
            end
          end else begin
            if (ps[49]) begin
              pos_q <= '0;
            end else if (ps >= w50) begin
              pos_q <= 32'(wsz - 33'd1);
            end else begin
              pos_q <= ps[31:0];
            end
            state_q <= ST_ST;
          end
        end
        ST_FP: begin
          if (div_done) begin
            if (p_q[49] && (div_rem != '0)) begin
              pos_q <= 32'(wsz - div_rem);
            end else begin
              pos_q <= div_rem[31:0];
            end
            state_q <= ST_ST;
          end
        end
        ST_ST: begin
          if (axis_q) begin
            nvy_q   <= v_q;
            npy_q   <= pos_q;
            state_q <= ST_EMIT;
          end else begin
            nvx_q   <= v_q;
            npx_q   <= pos_q;
            axis_q  <= 1'b1;
            state_q <= ST_FA;
          end
        end
        ST_EMIT: begin
          if (!out_valid_q || m_axis_tready) begin
            m_axis_tdata <= {npy_q, npx_q, nvy_q, nvx_q};
            out_valid_q  <= 1'b1;
            sum_x_q      <= '0;
            sum_y_q      <= '0;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;

  pfvi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go_q),
    .num_i   (div_num_q),
    .den_i   (div_den_q),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  pfvi_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_go_q),
    .x_i     (sq_x_q),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );
endmodule

// ===== sim/pfvi_motion_checker.sv =====
module pfvi_motion_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  input  logic [247:0]                s_axis_tdata,
  input  logic                        s_axis_tuser,
  input  logic                        s_axis_tlast,
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic [127:0]                m_axis_tdata,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_o,
  input  logic [pfvi_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [31:0]                 cfg_data_i,
  output int                          errors_o,
  output int                          pending_o
);
  import pfvi_pkg::*;

  localparam longint unsigned LIM = 64'd140737488355327;

  typedef struct packed {
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
  } motion_t;

  motion_t motion_q[$];

  longint unsigned radius, fscale, keep, dt, world;
  logic periodic;
  longint sum_x, sum_y;

  function automatic longint unsigned mag(longint v);
    return v < 0 ? 64'd0 - longint'(v) : longint'(v);
  endfunction

  function automatic longint with_sign(longint unsigned m, logic neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint sat_sum(longint v);
    if (v > longint'(LIM)) return longint'(LIM);
    if (v < -longint'(LIM)) return -longint'(LIM);
    return v;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint q16_mul_sat(longint a, longint unsigned b);
    longint unsigned m, hi, lo, val;
    m = mag(a);
    hi = (m >> 32) * b;
    lo = (m & 64'hFFFF_FFFF) * b;
    if (hi > (LIM >> 16)) val = LIM;
    else begin
      val = (hi << 16) + (lo >> 16);
      if (val > LIM) val = LIM;
    end
    return with_sign(val, a < 0);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint world_w();
    return world != 0 ? longint'(world) : 64'sd4294967296;
  endfunction

  function automatic longint wrap_delta(longint d);
    longint w;
    w = world_w();
    if (!periodic) return d;
    if (2 * d > w) return d - w;
    if (2 * d < -w) return d + w;
    return d;
  endfunction

  function automatic longint tent_force(longint unsigned r, longint a, longint unsigned beta);
    longint t, tent;
    longint unsigned q;
    if (r < beta) return -longint'(((beta - r) << 16) / beta);
    if (beta < r) begin
      t = 2 * longint'(r) - 65536 - longint'(beta);
      q = (mag(t) << 16) / (64'd65536 - beta);
      tent = 65536 - longint'(q);
      return (a * tent) / 32768;
    end
    return 0;
  endfunction

  function automatic longint place(longint p);
    longint w;
    w = world_w();
    if (periodic) begin
      if (p >= 0 && p < w) return p;
      p = p % w;
      if (p < 0) p += w;
      return p;
    end
    if (p < 0) return 0;
    if (p >= w) return w - 1;
    return p;
  endfunction

  // returns the new position; new velocity through vout
  function automatic longint advance_axis(longint sum, longint pos, longint vel,
                                          longint unsigned m, output longint vout);
    longint f, v, acc;
    f = q16_mul_sat(q16_mul_sat(sum, radius), fscale);
    v = with_sign((mag(vel) * keep) >> 16, vel < 0);
    acc = with_sign((mag(f) << 16) / m, f < 0);
    v = sat32(v + q16_mul_sat(acc, dt));
    vout = v;
    return place(pos + q16_mul_sat(v, dt));
  endfunction

  task automatic integrate_neighbor(logic [247:0] td, logic skip, logic last);
    longint sx, sy, ox, oy, a, dx, dy, f, vx, vy, px, py;
    longint unsigned beta, mx, my, qx, qy, sq, d, r, m;
    motion_t res;
    sx = longint'(td[31:0]);
    sy = longint'(td[63:32]);
    ox = longint'(td[95:64]);
    oy = longint'(td[127:96]);
    a = longint'($signed(td[143:128]));
    beta = longint'(td[159:144]);
    if (!skip) begin
      dx = wrap_delta(ox - sx);
      dy = wrap_delta(oy - sy);
      mx = mag(dx);
      my = mag(dy);
      if (mx < radius && my < radius) begin
        qx = mx * mx;
        qy = my * my;
        sq = qx + qy;
        if (sq >= qx && sq != 0 && sq < radius * radius) begin
          d = int_sqrt(sq);
          r = (d << 16) / radius;
          f = tent_force(r, a, beta);
          sum_x = sat_sum(sum_x + (dx * f) / longint'(d));
          sum_y = sat_sum(sum_y + (dy * f) / longint'(d));
        end
      end
    end
    if (last) begin
      m = longint'(td[247:224]);
      if (m == 0) m = 1;
      px = advance_axis(sum_x, sx, longint'($signed(td[191:160])), m, vx);
      py = advance_axis(sum_y, sy, longint'($signed(td[223:192])), m, vy);
      res.vel_x = vx[31:0];
      res.vel_y = vy[31:0];
      res.pos_x = px[31:0];
      res.pos_y = py[31:0];
      motion_q.push_back(res);
      sum_x = 0;
      sum_y = 0;
    end
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      errors_o++;
    end
  endtask

  assign pending_o = motion_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    motion_t e;
    if (!rst_ni) begin
      radius   = RST_RADIUS;
      fscale   = RST_FSCALE;
      keep     = RST_KEEP;
      dt       = RST_DT;
      world    = RST_WORLD;
      periodic = 1'b1;
      sum_x    = 0;
      sum_y    = 0;
      errors_o = 0;
      motion_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_addr_i)
          REG_RADIUS:   radius = cfg_data_i;
          REG_FSCALE:   fscale = cfg_data_i;
          REG_KEEP:     keep = cfg_data_i[15:0];
          REG_DT:       dt = cfg_data_i;
          REG_WORLD:    world = cfg_data_i;
          REG_PERIODIC: periodic = cfg_data_i[0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (motion_q.size() == 0) begin
          $error("unexpected output transaction %h", m_axis_tdata);
          errors_o++;
        end else begin
          e = motion_q.pop_front();
          check_field("new_vel_x", e.vel_x, m_axis_tdata[31:0]);
          check_field("new_vel_y", e.vel_y, m_axis_tdata[63:32]);
          check_field("new_pos_x", e.pos_x, m_axis_tdata[95:64]);
          check_field("new_pos_y", e.pos_y, m_axis_tdata[127:96]);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        integrate_neighbor(s_axis_tdata, s_axis_tuser, s_axis_tlast);
    end
  end

endmodule

// ===== sim/tb_pair_force_velocity_integrator_unit.sv =====
module tb_pair_force_velocity_integrator_unit;
  import pfvi_pkg::*;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [247:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [CFG_AW-1:0] cfg_addr_i;
  logic [31:0]  cfg_data_i;
  int           errors;
  int           pending;
  int           send_idle_pct;
  int           recv_stall_pct;
  longint unsigned cur_radius, cur_world;

  pair_force_velocity_integrator_unit dut (.*);

  pfvi_motion_checker checker_i (.*, .errors_o(errors), .pending_o(pending));

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #60_000_000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_neighbor(logic [31:0] sx, logic [31:0] sy, logic [31:0] ox,
                               logic [31:0] oy, logic [15:0] a, logic [15:0] beta,
                               logic skip, logic last, logic [31:0] vx,
                               logic [31:0] vy, logic [23:0] mass);
    logic rdy;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {mass, vy, vx, beta, a, oy, ox, sy, sx};
    s_axis_tuser  <= skip;
    s_axis_tlast  <= last;
    forever begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
      if (rdy) break;
    end
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [31:0] val);
    logic rdy;
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    forever begin
      @(negedge clk_i);
      rdy = cfg_ready_o;
      @(posedge clk_i);
      if (rdy) break;
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (800) @(posedge clk_i);
  endtask

  task automatic configure(logic [31:0] rad, logic [31:0] fs, logic [15:0] kp,
                           logic [31:0] step, logic [31:0] w, logic per);
    drain();
    write_reg(REG_RADIUS, rad);
    write_reg(REG_FSCALE, fs);
    write_reg(REG_KEEP, {16'd0, kp});
    write_reg(REG_DT, step);
    write_reg(REG_WORLD, w);
    write_reg(REG_PERIODIC, {31'd0, per});
    cur_radius = rad;
    cur_world = (w == 0) ? 64'd4294967296 : w;
  endtask

  // one particle with a short list of mostly nearby neighbors
  task automatic random_particle(inout int count);
    logic [31:0] sx, sy, ox, oy, vx, vy;
    logic [23:0] mass;
    longint unsigned reach;
    int n, sel;
    n = $urandom_range(1, 6);
    sx = $urandom % cur_world;
    sy = $urandom % cur_world;
    vx = ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, 2_000_000) - 1_000_000;
    vy = ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, 2_000_000) - 1_000_000;
    sel = $urandom_range(15);
    mass = (sel == 0) ? 24'd0 : (sel < 3) ? 24'($urandom) : 24'($urandom_range(1, 4 * 65536));
    reach = cur_radius + cur_radius / 4 + 1;
    if (reach > 64'hFFFF_FFFF) reach = 64'hFFFF_FFFF;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(15);
      if (sel == 0) begin
        ox = $urandom;
        oy = $urandom;
      end else if (sel == 1) begin
        ox = sx + 32'(cur_world / 2);
        oy = sy;
      end else begin
        ox = sx + 32'(($urandom_range(1) ? 64'd0 : 64'd0 - 64'd1) * {$urandom, $urandom} % reach);
        oy = sy + 32'(($urandom_range(1) ? 64'd0 : 64'd0 - 64'd1) * {$urandom, $urandom} % reach);
        ox = $urandom_range(1) ? sx + 32'({$urandom, $urandom} % reach)
                               : sx - 32'({$urandom, $urandom} % reach);
        oy = $urandom_range(1) ? sy + 32'({$urandom, $urandom} % reach)
                               : sy - 32'({$urandom, $urandom} % reach);
      end
      send_neighbor(sx, sy, ox, oy, 16'($urandom), ($urandom_range(3) == 0) ?
                    16'($urandom_range(0, 3)) : 16'($urandom),
                    $urandom_range(9) == 0, i == n - 1, vx, vy, mass);
      count++;
    end
  endtask

  initial begin
    int count, mode;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_addr_i    = REG_RADIUS;
    cfg_data_i    = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cur_radius = RST_RADIUS;
    cur_world  = RST_WORLD;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, skips, ties and zero cases, first at reset settings, then under two other configurations
    send_neighbor(32'd100000, 32'd100000, 32'd130000, 32'd100000, 16'h7FFF, 16'd0,
                  1'b0, 1'b0, 32'd0, 32'd0, 24'd65536);
    send_neighbor(32'd100000, 32'd100000, 32'd100000, 32'd140000, 16'h8000, 16'hFFFF,
                  1'b0, 1'b0, 32'd0, 32'd0, 24'd65536);
    send_neighbor(32'd100000, 32'd100000, 32'd100000, 32'd100000, 16'h7FFF, 16'd20000,
                  1'b0, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 24'd0);
    send_neighbor(32'd0, 32'd0, 32'd65535000, 32'd1, 16'h8000, 16'd30000,
                  1'b0, 1'b0, 32'd0, 32'd0, 24'd1);
    send_neighbor(32'd0, 32'd0, 32'd32768000, 32'd0, 16'h7FFF, 16'd30000,
                  1'b0, 1'b0, 32'd0, 32'd0, 24'd1);
    send_neighbor(32'd0, 32'd0, 32'd10, 32'd10, 16'h7FFF, 16'd30000,
                  1'b1, 1'b1, 32'hFFFF_FFFF, 32'd1, 24'hFF_FFFF);
    send_neighbor(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 16'h7FFF, 16'd100,
                  1'b0, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 24'd1);
    send_neighbor(32'd500000, 32'd500000, 32'd500000, 32'd700000, 16'h4000, 16'd0,
                  1'b1, 1'b1, 32'd0, 32'd0, 24'd65536);
    configure(32'hFFFF_FFFF, 32'd65536, 16'd65535, 32'd65536, 32'd0, 1'b0);
    send_neighbor(32'd1000, 32'd1000, 32'd1001, 32'd1000, 16'h7FFF, 16'd0,
                  1'b0, 1'b0, 32'd0, 32'd0, 24'd65536);
    send_neighbor(32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000, 16'hFFFF,
                  1'b0, 1'b0, 32'd0, 32'd0, 24'd65536);
    send_neighbor(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8001_0000, 16'h7FFF,
                  16'd1, 1'b0, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 24'd1);
    configure(32'd0, 32'd0, 16'd0, 32'd0, 32'd1, 1'b1);
    send_neighbor(32'd5, 32'd5, 32'd6, 32'd6, 16'h7FFF, 16'd0,
                  1'b0, 1'b1, 32'd100, 32'hFFFF_FF00, 24'd5);

    count = 0;
    mode = 0;
    for (int s = 0; s < 5; s++) begin
      case (s)
        0: configure(32'd262144, 32'd65536, 16'd60000, 32'd6554, 32'd4194304, 1'b1);
        1: configure(32'd1, 32'hFFFF_FFFF, 16'd0, 32'hFFFF_FFFF, 32'd1, 1'b0);
        2: configure(32'hFFFF_FFFF, 32'd0, 16'd65535, 32'd0, 32'd0, 1'b1);
        3: configure(32'd131072, 32'hFFFF_FFFF, 16'd32768, 32'd65536, 32'd655360, 1'b0);
        default: configure(32'd524288, 32'd196608, 16'd65000, 32'd1000, 32'hFFFF_FFFF, 1'b1);
      endcase
      while (count < (s + 1) * 250) begin
        case (mode % 4)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
          default: begin send_idle_pct = 35; recv_stall_pct = 35; end
        endcase
        if ((count % 60) < 4) mode++;
        random_particle(count);
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (1000) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
